### rtl/core/urs_pkg.sv
// Shared types and constants for the unique random sequence drawer.
package urs_pkg;

   localparam int CNT_W     = 11;   // pool numbers, live count, index
   localparam int SEQ_W     = 16;   // sequence length and word counters
   localparam int WORD_W    = 32;   // random word
   localparam int DIV_STEPS = WORD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int RSP_W     = 16;   // result tdata, padded to whole bytes
   localparam int CSR_W     = 16;   // widest register
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0] RESET_POOL_SIZE  = 11'd1024;
   localparam logic [SEQ_W-1:0] RESET_SEQ_LENGTH = 16'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_LENGTH = 1'b1;

   localparam logic MODE_RESTART = 1'b0;
   localparam logic MODE_WORD    = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic refill;         // reload counters, arm the mark clearing pass
      logic clr_step;       // clear one mark entry
      logic start_div;      // load the random word, clear the remainder
      logic div_step;       // one restoring division step
      logic mark_finished;  // sequence length reached before this word
      logic commit;         // apply the outcome of one word
      logic cmp_start;      // open a compaction pass
      logic cmp_step;       // move one pool entry during compaction
      logic cmp_end;        // close the compaction pass
      logic addr_cmp;       // memories addressed by the pass counter
   } urs_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic pass_done;   // clearing pass has covered its range
      logic cmp_done;    // compaction has read every live slot
      logic no_draw;     // finished or empty pool
      logic seq_done;    // drawn count has reached the sequence length
      logic div_last;    // final division step
      logic hit_free;    // addressed slot is unmarked
      logic out_free;    // result register can take a new result
      logic last_draw;   // a hit now would end the sequence
      logic batch_full;  // this word closes the batch
   } urs_status_type;

endpackage

### rtl/core/unique_random_sequence_drawer.sv
// Top level of the unique random sequence drawer: controller plus datapath.
//
// Draws distinct numbers 1..pool_size in random order, one request per random word.
// Request channel (req_): tuser carries the mode (restart or random word), tdata the
// 32-bit word. A restart refills the pool; a word is reduced modulo the live count
// and, if that pool slot is still unmarked, its number goes out on the response
// channel (rsp_) with tlast on the final number of the sequence.
// Registers pool_size (index 0) and seq_length (index 1) are written through the
// csr_ port; pool_size takes effect at the next restart.
// Steps: an accepted word goes through 32 steps of the bit-serial remainder unit, one
// memory read and one decide before it reaches the result register; the next request
// is taken only after its decide step. A batch end or sequence end adds a compaction
// pass through the pool memory. A restart clears the marks of the previous batch.
// After reset all POOL_DEPTH mark entries are cleared; no request is
// taken meanwhile (configuration writes are). A stalled receiver holds the result
// in the output register; the next word is still accepted and worked on, and only
// waits at its decide step if it would produce a second result.
module unique_random_sequence_drawer #(
   parameter int POOL_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [urs_pkg::WORD_W-1:0]    req_tdata,   // [31:0] random_word
   input  logic                          req_tuser,   // [0] mode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [urs_pkg::RSP_W-1:0]     rsp_tdata,   // [10:0] drawn_number, rest zero
   output logic                          rsp_tlast,   // last
   input  logic                          csr_we,
   input  logic [urs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [urs_pkg::CSR_W-1:0]     csr_wdata
);
   import urs_pkg::*;

   urs_cmd_type      cmd;
   urs_status_type   status;
   logic [CNT_W-1:0] rsp_number;

   // sequence the clearing, division, draw and compaction steps
   urs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold the pool, marks, counters and the result register
   urs_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_number (rsp_number),
      .rsp_last   (rsp_tlast)
   );

   // pad the drawn number to whole bytes
   assign rsp_tdata = {{(RSP_W-CNT_W){1'b0}}, rsp_number};

   // a new result is only loaded by a committed draw
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("response raised without a committed draw");

   // never overwrite a result the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status.hit_free) |-> status.out_free)
      else $error("draw committed over a pending response");

   // drawn numbers are never zero
   a_number_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CNT_W-1:0] != '0))
      else $error("drawn number is zero");

   // no request is taken while the divider, a clearing pass or a compaction pass is running
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(cmd.div_step || cmd.cmp_step || cmd.clr_step))
      else $error("request taken while busy");

endmodule

### rtl/core/urs_ctrl.sv
// Controller state machine sequencing clearing, division, draw and compaction.
module urs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_mode,
   output logic                    req_tready,
   input  urs_pkg::urs_status_type status,
   output urs_pkg::urs_cmd_type    cmd
);
   import urs_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_LOOK,
      S_DECIDE,
      S_CMP_RD,
      S_CMP_WR
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            if (status.pass_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_mode == MODE_RESTART) begin
                  cmd.refill = 1'b1;
                  state_in   = S_CLEAR;
               end else if (status.no_draw) begin
                  state_in = S_IDLE;
               end else if (status.seq_done) begin
                  cmd.mark_finished = 1'b1;
               end else begin
                  cmd.start_div = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // hold while a hit would overwrite an untaken result
            if (!(status.hit_free && !status.out_free)) begin
               cmd.commit = 1'b1;
               if ((status.hit_free && status.last_draw) || status.batch_full) begin
                  cmd.cmp_start = 1'b1;
                  state_in      = S_CMP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CMP_RD: begin
            cmd.addr_cmp = 1'b1;
            if (status.cmp_done) begin
               cmd.cmp_end = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_CMP_WR;
            end
         end
         S_CMP_WR: begin
            cmd.addr_cmp = 1'b1;
            cmd.cmp_step = 1'b1;
            state_in     = S_CMP_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/urs_datapath.sv
// Datapath: pool and mark memories, divider, counters, registers and result stage.
module urs_datapath #(
   parameter int POOL_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [urs_pkg::WORD_W-1:0]      req_word,
   input  logic                            csr_we,
   input  logic [urs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [urs_pkg::CSR_W-1:0]       csr_wdata,
   input  urs_pkg::urs_cmd_type            cmd,
   output urs_pkg::urs_status_type         status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [urs_pkg::CNT_W-1:0]       rsp_number,
   output logic                            rsp_last
);
   import urs_pkg::*;

   localparam int AW        = $clog2(POOL_DEPTH);
   localparam int PW        = AW + 1;
   localparam int DEPTH_CAP = (POOL_DEPTH > 2047) ? 2047 : POOL_DEPTH;
   localparam int RESET_N   = (DEPTH_CAP < 1024) ? DEPTH_CAP : 1024;

   localparam logic [CNT_W-1:0] CAP_V   = CNT_W'(DEPTH_CAP);
   localparam logic [CNT_W-1:0] RESET_V = CNT_W'(RESET_N);

   logic [CNT_W-1:0] pool_mem [POOL_DEPTH];
   logic             mark_mem [POOL_DEPTH];

   logic [CNT_W-1:0]  pool_size_ff, pool_size_in;
   logic [SEQ_W-1:0]  seq_len_ff, seq_len_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [SEQ_W-1:0]  drawn_ff, drawn_in;
   logic [SEQ_W-1:0]  bwords_ff, bwords_in;
   logic [CNT_W-1:0]  bmarked_ff, bmarked_in;
   logic              finished_ff, finished_in;
   logic              fresh_ff, fresh_in;
   logic [PW-1:0]     pass_ff, pass_in;
   logic [PW-1:0]     limit_ff, limit_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_number_ff, rsp_number_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]  pool_rd_ff;
   logic              mark_rd_ff;

   logic [AW-1:0]    rd_addr;
   logic [CNT_W-1:0] base_idx;
   logic [CNT_W-1:0] entry_value;
   logic [CNT_W-1:0] n_eff;
   logic [CNT_W:0]   rem_sh;
   logic [CNT_W:0]   rem_sub;
   logic             hit;
   logic             mark_we;
   logic [AW-1:0]    mark_wa;
   logic             pool_we;

   assign rd_addr     = cmd.addr_cmp ? pass_ff[AW-1:0] : AW'(rem_ff);
   assign base_idx    = cmd.addr_cmp ? CNT_W'(pass_ff) : rem_ff;
   // after a refill slot i holds i+1 until the first compaction rewrites it
   assign entry_value = fresh_ff ? (base_idx + CNT_W'(1)) : pool_rd_ff;
   assign n_eff       = (pool_size_ff > CAP_V) ? CAP_V : pool_size_ff;
   assign rem_sh      = {rem_ff, word_ff[WORD_W-1]};
   assign rem_sub     = rem_sh - {1'b0, live_ff};
   assign hit         = cmd.commit && !mark_rd_ff;

   assign mark_we = cmd.clr_step || cmd.cmp_step || hit;
   assign mark_wa = cmd.commit ? AW'(rem_ff) : pass_ff[AW-1:0];
   assign pool_we = cmd.cmp_step && !mark_rd_ff;

   always_comb begin
      status.pass_done  = (pass_ff >= limit_ff);
      status.cmp_done   = (pass_ff >= PW'(live_ff));
      status.no_draw    = finished_ff || (live_ff == '0);
      status.seq_done   = (drawn_ff >= seq_len_ff);
      status.div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
      status.hit_free   = !mark_rd_ff;
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.last_draw  = (({1'b0, drawn_ff} + (SEQ_W+1)'(1)) >= {1'b0, seq_len_ff})
                       || (({1'b0, bmarked_ff} + (CNT_W+1)'(1)) >= {1'b0, live_ff});
      status.batch_full = (({1'b0, bwords_ff} + (SEQ_W+1)'(1)) >= {1'b0, seq_len_ff});
   end

   always_comb begin
      pool_size_in  = pool_size_ff;
      seq_len_in    = seq_len_ff;
      live_in       = live_ff;
      drawn_in      = drawn_ff;
      bwords_in     = bwords_ff;
      bmarked_in    = bmarked_ff;
      finished_in   = finished_ff;
      fresh_in      = fresh_ff;
      pass_in       = pass_ff;
      limit_in      = limit_ff;
      wr_in         = wr_ff;
      word_in       = word_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_number_in = rsp_number_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_POOL_SIZE:  pool_size_in = csr_wdata[CNT_W-1:0];
            CSR_SEQ_LENGTH: seq_len_in   = csr_wdata[SEQ_W-1:0];
            default:        ;
         endcase
      end

      if (cmd.refill) begin
         limit_in    = PW'(live_ff);   // marks set since the last compaction lie below this
         pass_in     = '0;
         live_in     = n_eff;
         drawn_in    = '0;
         bwords_in   = '0;
         bmarked_in  = '0;
         fresh_in    = 1'b1;
         finished_in = (n_eff == '0) || (seq_len_ff == '0);
      end

      if (cmd.clr_step) begin
         pass_in = pass_ff + PW'(1);
      end

      if (cmd.mark_finished) begin
         finished_in = 1'b1;
      end

      if (cmd.start_div) begin
         word_in    = req_word;
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         rem_in     = (rem_sh >= {1'b0, live_ff}) ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         word_in    = {word_ff[WORD_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.commit) begin
         bwords_in = bwords_ff + SEQ_W'(1);
         if (hit) begin
            bmarked_in    = bmarked_ff + CNT_W'(1);
            drawn_in      = drawn_ff + SEQ_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_number_in = entry_value;
            rsp_last_in   = status.last_draw;
            if (status.last_draw) begin
               finished_in = 1'b1;
            end
         end
      end

      if (cmd.cmp_start) begin
         pass_in = '0;
         wr_in   = '0;
      end

      if (cmd.cmp_step) begin
         pass_in = pass_ff + PW'(1);
         if (!mark_rd_ff) begin
            wr_in = wr_ff + CNT_W'(1);
         end
      end

      if (cmd.cmp_end) begin
         live_in    = wr_ff;
         bwords_in  = '0;
         bmarked_in = '0;
         fresh_in   = 1'b0;
         if (wr_ff == '0) begin
            finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= RESET_POOL_SIZE;
         seq_len_ff   <= RESET_SEQ_LENGTH;
         live_ff      <= RESET_V;
         drawn_ff     <= '0;
         bwords_ff    <= '0;
         bmarked_ff   <= '0;
         finished_ff  <= 1'b0;
         fresh_ff     <= 1'b1;
         pass_ff      <= '0;
         limit_ff     <= PW'(POOL_DEPTH);
         wr_ff        <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_size_ff <= pool_size_in;
         seq_len_ff   <= seq_len_in;
         live_ff      <= live_in;
         drawn_ff     <= drawn_in;
         bwords_ff    <= bwords_in;
         bmarked_ff   <= bmarked_in;
         finished_ff  <= finished_in;
         fresh_ff     <= fresh_in;
         pass_ff      <= pass_in;
         limit_ff     <= limit_in;
         wr_ff        <= wr_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      rem_ff        <= rem_in;
      rsp_number_ff <= rsp_number_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      pool_rd_ff <= pool_mem[rd_addr];
      mark_rd_ff <= mark_mem[rd_addr];
      if (mark_we) begin
         mark_mem[mark_wa] <= cmd.commit;
      end
      if (pool_we) begin
         pool_mem[AW'(wr_ff)] <= entry_value;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_number = rsp_number_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### tb/sv/tb_unique_random_sequence_drawer.sv
// Self-checking testbench for the unique random sequence drawer.
module tb_unique_random_sequence_drawer;
   timeunit 1ns;
   timeprecision 1ps;

   import urs_pkg::*;

   localparam int POOL_DEPTH      = 1024;
   // Idle time before a register write: covers a full compaction pass,
   // a restart clearing pass and one word in flight.
   localparam int QUIET_CYCLES    = 3 * POOL_DEPTH + 64;
   // Watchdog: cycles with no request and no result moving.
   localparam int WATCHDOG_LIMIT  = 16 * POOL_DEPTH;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int RANDOM_BUDGET   = 36;

   // One drawn number as it should appear on the result channel
   typedef struct packed {
      logic [CNT_W-1:0] number;
      logic             last;
   } draw_type;

   // ---------------------------------------------------------------------
   // Clock, reset and the block's ports (all inputs known from time zero)
   // ---------------------------------------------------------------------
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [WORD_W-1:0]    req_tdata  = '0;
   logic                 req_tuser  = MODE_RESTART;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   unique_random_sequence_drawer #(
      .POOL_DEPTH(POOL_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hold reset from time zero, then release it for good
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shared run state
   // ---------------------------------------------------------------------
   draw_type expected_draws[$];  // numbers still owed by the block, oldest first
   int    fault_count     = 0;
   int    requests_sent   = 0;
   int    restarts_sent   = 0;
   int    draws_checked   = 0;
   int    sequence_ends   = 0;
   int    settings_used   = 0;
   bit    sender_gaps     = 1'b1;
   bit    receiver_stalls = 1'b1;
   int    hold_off_cycles = 0;   // one-shot request for a long receiver stall

   // ---------------------------------------------------------------------
   // Sampling-without-replacement predictor, own copy of state and registers
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] slot_number [POOL_DEPTH];
   bit               slot_taken  [POOL_DEPTH];
   logic [CNT_W-1:0] cfg_pool_size;
   logic [SEQ_W-1:0] cfg_seq_len;
   int unsigned      live_slots;
   int unsigned      drawn_total;
   int unsigned      words_in_batch;
   int unsigned      taken_in_batch;
   bit               seq_finished;

   // Reload the pool with 1..pool_size (clipped to the depth) and clear all marks
   function automatic void refill_pool();
      int unsigned n;
      int          i;
      n = (cfg_pool_size > POOL_DEPTH) ? POOL_DEPTH : cfg_pool_size;
      for (i = 0; i < n; i++) slot_number[i] = CNT_W'(i + 1);
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      live_slots     = n;
      drawn_total    = 0;
      words_in_batch = 0;
      taken_in_batch = 0;
      seq_finished   = (n == 0) || (cfg_seq_len == 0);
   endfunction

   // Squeeze marked slots out of the live part of the pool, keeping order
   function automatic void compact_pool();
      int unsigned kept;
      int unsigned rd;
      kept = 0;
      for (rd = 0; rd < live_slots; rd++) begin
         if (!slot_taken[rd]) begin
            slot_number[kept] = slot_number[rd];
            kept++;
         end
      end
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      live_slots     = kept;
      words_in_batch = 0;
      taken_in_batch = 0;
      if (kept == 0) seq_finished = 1'b1;
   endfunction

   function automatic void reset_predictor();
      cfg_pool_size = RESET_POOL_SIZE;
      cfg_seq_len   = RESET_SEQ_LENGTH;
      refill_pool();
   endfunction

   // Advance the predictor by one accepted request; returns 1 when it draws a number
   function automatic bit predict_request(input logic mode, input logic [WORD_W-1:0] word,
                                          output draw_type draw);
      int unsigned idx;
      bit          hit;
      bit          closes;
      draw   = '0;
      hit    = 1'b0;
      closes = 1'b0;
      if (mode == MODE_RESTART) begin
         refill_pool();
         return 1'b0;
      end
      if (seq_finished || live_slots == 0 || live_slots > POOL_DEPTH) return 1'b0;
      // Length reached (possibly lowered since the last word): stop for good
      if (drawn_total >= cfg_seq_len) begin
         seq_finished = 1'b1;
         return 1'b0;
      end
      idx = word % live_slots;
      if (!slot_taken[idx]) begin
         slot_taken[idx] = 1'b1;
         taken_in_batch++;
         drawn_total++;
         draw.number = slot_number[idx];
         hit         = 1'b1;
         closes      = (drawn_total >= cfg_seq_len) || (taken_in_batch >= live_slots);
         draw.last   = closes;
      end
      // A word landing on a marked slot still counts toward the batch
      words_in_batch++;
      if (closes) begin
         compact_pool();
         seq_finished = 1'b1;
      end else if (words_in_batch >= cfg_seq_len) begin
         compact_pool();
      end
      return hit;
   endfunction

   // True while a random word can still produce a number
   function automatic bit can_draw();
      return !seq_finished && live_slots != 0 && drawn_total < cfg_seq_len;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offer one request, hold it until taken, then update the prediction
   task automatic send_request(input logic mode, input logic [WORD_W-1:0] word);
      draw_type draw;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_request(mode, word, draw)) expected_draws.push_back(draw);
      requests_sent++;
      if (mode == MODE_RESTART) restarts_sent++;
   endtask

   // Drop the request line, wait for every owed number, then let the block go idle
   task automatic drain_and_wait();
      req_tvalid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write one register; the spare cycle keeps one assignment per edge on csr_we
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_POOL_SIZE) cfg_pool_size = value[CNT_W-1:0];
      else if (index == CSR_SEQ_LENGTH) cfg_seq_len = value[SEQ_W-1:0];
      @(posedge clock);
   endtask

   // Settle the block, then load both registers (random junk above the pool size)
   task automatic configure(input logic [CNT_W-1:0] pool, input logic [SEQ_W-1:0] seq_len);
      drain_and_wait();
      write_register(CSR_POOL_SIZE, {(CSR_W - CNT_W)'($urandom), pool});
      write_register(CSR_SEQ_LENGTH, seq_len);
      settings_used++;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, live_slots + 1);
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_pool_size();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return CNT_W'($urandom_range(POOL_DEPTH + 1, (1 << CNT_W) - 1));
         2:       return CNT_W'(POOL_DEPTH);
         default: return CNT_W'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [SEQ_W-1:0] pick_seq_length();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return SEQ_W'($urandom_range(1, 3));
         default: return SEQ_W'($urandom_range(2, 48));
      endcase
   endfunction

   // Mostly restart-then-draw sequences; some stray words and cut-short sequences.
   // Only requests that can change the outcome count toward the budget.
   task automatic run_sequences(input int budget);
      int issued;
      int spare;
      bit broken;
      issued = 0;
      while (issued < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            if (can_draw()) issued++;
            send_request(MODE_WORD, pick_word());
         end
         send_request(MODE_RESTART, $urandom);
         issued++;
         broken = ($urandom_range(0, 5) == 0);
         spare  = $urandom_range(0, 2);   // words past the end, which must draw nothing
         while (issued < budget && (can_draw() || spare > 0)) begin
            if (broken && $urandom_range(0, 7) == 0) break;
            if (can_draw()) issued++;
            else spare--;
            send_request(MODE_WORD, pick_word());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random short stalls, plus one long hold-off when asked
   // ---------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            stall_left      = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic note_fault(input string what, input logic [RSP_W-1:0] want_data,
                             input logic want_last);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t: %s: expected tdata %0d tlast %0b, got tdata %0d tlast %0b",
                  $time, what, want_data, want_last, rsp_tdata, rsp_tlast);
   endtask

   // Compare every accepted result with the oldest owed number, field by field
   always @(posedge clock) begin : check_draws
      draw_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_draws.size() == 0) begin
            note_fault("result with no number owed", '0, 1'b0);
         end else begin
            want = expected_draws.pop_front();
            if (rsp_tdata[CNT_W-1:0] !== want.number || rsp_tdata[RSP_W-1:CNT_W] !== '0 ||
                rsp_tlast !== want.last)
               note_fault("wrong result", RSP_W'(want.number), want.last);
            draws_checked++;
            if (want.last) sequence_ends++;
         end
      end
   end

   // Abandon the run when nothing moves on either channel for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: nothing moved for %0d cycles, %0d numbers still owed",
               quiet, expected_draws.size());
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset registers: largest draw from the top word, smallest from zero, a repeat
   // landing on a marked slot, and a restart whose word must be ignored
   task automatic test_default_config();
      send_request(MODE_WORD, '1);
      send_request(MODE_WORD, '0);
      send_request(MODE_WORD, '0);
      send_request(MODE_RESTART, '1);
   endtask

   // Pool size above the depth clips to the depth; longest sequence length
   task automatic test_oversize_pool();
      configure('1, '1);
      send_request(MODE_RESTART, '0);
      send_request(MODE_WORD, WORD_W'(POOL_DEPTH - 1));
      send_request(MODE_WORD, WORD_W'(POOL_DEPTH));
      send_request(MODE_WORD, 32'h8000_0000);
   endtask

   // Two-slot pool: a marked-slot hit, the closing number, words after the end,
   // and a pool size that only counts from the next restart
   task automatic test_marked_slot_and_finish();
      configure(2, '1);
      send_request(MODE_RESTART, $urandom);
      send_request(MODE_WORD, 0);
      send_request(MODE_WORD, 2);
      send_request(MODE_WORD, 1);
      send_request(MODE_WORD, 5);
      drain_and_wait();
      write_register(CSR_POOL_SIZE, 1);
      send_request(MODE_WORD, $urandom);
      send_request(MODE_RESTART, $urandom);
      send_request(MODE_WORD, '1);
   endtask

   // Empty pool and zero sequence length: words draw nothing
   task automatic test_empty_pool_and_length();
      configure(0, 16);
      send_request(MODE_RESTART, $urandom);
      send_request(MODE_WORD, $urandom);
      configure(5, 0);
      send_request(MODE_RESTART, $urandom);
      send_request(MODE_WORD, $urandom);
   endtask

   // Sequence length lowered mid-sequence stops drawing at once
   task automatic test_live_register_update();
      configure(10, 8);
      send_request(MODE_RESTART, $urandom);
      send_request(MODE_WORD, 3);
      send_request(MODE_WORD, 4);
      drain_and_wait();
      write_register(CSR_SEQ_LENGTH, 1);
      write_register(CSR_POOL_SIZE, 5);
      send_request(MODE_WORD, 7);
      send_request(MODE_RESTART, $urandom);
      send_request(MODE_WORD, $urandom);
   endtask

   // Random settings, extremes first, with idling switched on and off per phase
   task automatic test_random_sequences();
      logic [CNT_W-1:0] pool;
      logic [SEQ_W-1:0] seq_len;
      int               phase;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               pool    = 1;
               seq_len = '1;
            end
            1: begin
               pool    = CNT_W'(POOL_DEPTH);
               seq_len = 1;
            end
            default: begin
               pool    = pick_pool_size();
               seq_len = pick_seq_length();
            end
         endcase
         sender_gaps     = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         configure(pool, seq_len);
         run_sequences(RANDOM_BUDGET);
      end
   endtask

   // Hold the receiver off while requests keep coming, so the block backs up
   task automatic test_output_backpressure();
      receiver_stalls = 1'b0;
      sender_gaps     = 1'b0;
      configure(24, 24);
      send_request(MODE_RESTART, $urandom);
      hold_off_cycles = HOLD_OFF_CYCLES;
      while (can_draw()) send_request(MODE_WORD, $urandom);
   endtask

   // Close with back-to-back traffic and no idling on either side
   task automatic test_steady_stream();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      configure(32, 40);
      run_sequences(50);
   endtask

   initial begin
      reset_predictor();
      wait (reset == 1'b0);
      test_default_config();
      test_oversize_pool();
      test_marked_slot_and_finish();
      test_empty_pool_and_length();
      test_live_register_update();
      test_random_sequences();
      test_output_backpressure();
      test_steady_stream();
      drain_and_wait();
      $display("Sent %0d requests (%0d restarts) across %0d register settings; %0d numbers",
               requests_sent, restarts_sent, settings_used, draws_checked);
      $display("checked, %0d sequence ends, %0d mismatches, incl. a long receiver hold-off.",
               sequence_ends, fault_count);
      if (fault_count == 0 && expected_draws.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
